/* src/deq_pkg.sv */
// Shared types and constants of the double-ended queue unit.
package deq_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int WORD_W          = 32;
    localparam int ENTRY_COUNT_W   = 5;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT,
        MODE_PUSH_BACK,
        MODE_POP_FRONT,
        MODE_POP_BACK
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE,
        ST_POP_EMPTY,
        ST_PUSH_FULL
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } t_state;

    // Command from controller to datapath.
    typedef struct packed {
        logic    exec;
        logic    write;
        logic    read;
        t_mode   mode;
        t_status status;
    } t_deq_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic full;
        logic empty;
    } t_deq_sts;

endpackage

/* src/deq_ctrl.sv */
// Controller of the double-ended queue: handshakes and operation decode.
module deq_ctrl
    import deq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_mode    i_mode,
    input  logic     i_out_stall,
    input  t_deq_sts i_sts,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_deq_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   is_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        // A new item may enter when no result is held or the held one leaves now.
        o_in_stall  = (r_state == S_HOLD) && i_out_stall;
        o_out_valid = (r_state == S_HOLD);
        accept      = i_in_valid && !o_in_stall;
        is_push     = (i_mode == MODE_PUSH_FRONT) || (i_mode == MODE_PUSH_BACK);

        o_cmd.exec   = accept;
        o_cmd.mode   = i_mode;
        o_cmd.write  = accept && is_push && !i_sts.full;
        o_cmd.read   = accept && !is_push && !i_sts.empty;
        o_cmd.status = ST_DONE;
        if (is_push && i_sts.full) begin
            o_cmd.status = ST_PUSH_FULL;
        end else if (!is_push && i_sts.empty) begin
            o_cmd.status = ST_POP_EMPTY;
        end

        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (accept) begin
                    n_state = S_HOLD;
                end else if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* src/deq_dpath.sv */
// Datapath of the double-ended queue: ring store, indices and result registers.
module deq_dpath
    import deq_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_deq_cmd                        i_cmd,
    input  logic signed [WORD_W-1:0]        i_push_value,
    output t_deq_sts                        o_sts,
    output logic signed [WORD_W-1:0]        o_pop_value,
    output logic        [1:0]               o_status,
    output logic        [ENTRY_COUNT_W-1:0] o_entry_count,
    output logic                            o_is_empty
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_rd_data;

    logic [IDX_W-1:0] r_front;
    logic [IDX_W-1:0] n_front;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] front_inc;
    logic [CNT_W-1:0] tail_off;
    logic [SUM_W-1:0] tail_sum;
    logic [IDX_W-1:0] tail_slot;
    logic [IDX_W-1:0] addr;

    t_status          r_res_status;
    logic [CNT_W-1:0] r_res_count;
    logic             r_res_pop;

    always_comb begin
        o_sts.full  = (r_count == CNT_W'(DEPTH));
        o_sts.empty = (r_count == '0);

        front_dec = (r_front == '0) ? IDX_W'(DEPTH - 1) : r_front - 1'b1;
        front_inc = (r_front == IDX_W'(DEPTH - 1)) ? '0 : r_front + 1'b1;

        // Back slot for a push, last held slot for a pop; the sum stays below 2*DEPTH but for a pop on an empty queue.
        tail_off  = (i_cmd.mode == MODE_POP_BACK) ? r_count - 1'b1 : r_count;
        tail_sum  = SUM_W'(r_front) + SUM_W'(tail_off);
        tail_slot = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                : IDX_W'(tail_sum);

        n_front = r_front;
        n_count = r_count;
        addr    = tail_slot;
        case (i_cmd.mode)
            MODE_PUSH_FRONT: begin
                addr = front_dec;
                if (i_cmd.write) begin
                    n_front = front_dec;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_PUSH_BACK: begin
                if (i_cmd.write) begin
                    n_count = r_count + 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                addr = r_front;
                if (i_cmd.read) begin
                    n_front = front_inc;
                    n_count = r_count - 1'b1;
                end
            end
            MODE_POP_BACK: begin
                if (i_cmd.read) begin
                    n_count = r_count - 1'b1;
                end
            end
            default: addr = tail_slot;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem[addr] <= VALUE_WIDTH'($unsigned(i_push_value));
        end
        if (i_cmd.read) begin
            r_rd_data <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_status <= i_cmd.status;
            r_res_count  <= n_count;
            r_res_pop    <= i_cmd.read;
        end
    end

    assign o_pop_value   = r_res_pop ? WORD_W'(r_rd_data) : '0;
    assign o_status      = r_res_status;
    assign o_entry_count = ENTRY_COUNT_W'(r_res_count);
    assign o_is_empty    = (r_res_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_refused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && (i_cmd.status != ST_DONE) |=> $stable(r_count) && $stable(r_front))
        else $error("refused operation changed queue state");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |=> r_count == $past(r_count) + 1'b1)
        else $error("push did not add one entry");

    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.write && i_cmd.read))
        else $error("store written and read by one item");

endmodule

/* src/double_ended_queue_unit.sv */
// Top level of the double-ended queue unit: controller and datapath joined.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+--------------------------------------
//  in      | into unit | i_in_valid / o_in_stall    | i_mode, i_push_value
//  out     | from unit | o_out_valid / i_out_stall  | o_pop_value, o_status,
//          |           |                            | o_entry_count, o_is_empty
//
// Each item yields exactly one result, in the cycle after it is accepted; the pop
// data comes from the registered read port of the ring store.
// One item per cycle is sustained while results are taken: a new item enters in
// the cycle in which the held result leaves.
// While a held result is stalled, the input is stalled too.
// Reset is synchronous and active low; it empties the queue at once by clearing
// the front index and the entry count. The store itself is not cleared.
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic        [1:0]               i_mode,
    input  logic signed [WORD_W-1:0]        i_push_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [WORD_W-1:0]        o_pop_value,
    output logic        [1:0]               o_status,
    output logic        [ENTRY_COUNT_W-1:0] o_entry_count,
    output logic                            o_is_empty
);

    t_deq_cmd cmd;
    t_deq_sts sts;

    // The controller decodes the operation against the full and empty flags.
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (t_mode'(i_mode)),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // The datapath holds the ring, moves the indices and registers the result.
    deq_dpath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_push_value  (i_push_value),
        .o_sts         (sts),
        .o_pop_value   (o_pop_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty)
    );

endmodule
